// ===== src/tle_pkg.sv =====
package tle_pkg;

    localparam int CW   = 32;
    localparam int EW   = 33;
    localparam int OPW  = 72;
    localparam int PRW  = 144;
    localparam int DENW = 128;
    localparam int QW   = 51;
    localparam int DIVW = DENW + QW + 1;
    localparam int VW   = 48;
    localparam int NE   = 9;
    localparam int NC   = 12;
    localparam int DGW  = 16;
    localparam int NDIG = (OPW + DGW - 1) / DGW;

    localparam logic [4:0] SEL_C      = 5'd9;
    localparam logic [4:0] CROSS_LAST = 5'd17;
    localparam logic [4:0] SUM_LAST   = 5'd2;
    localparam logic [3:0] JK_LAST    = 4'd15;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [EW-1:0] t_edge;
    typedef t_edge t_edges [NE];

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_MGO,
        BS_MWAIT,
        BS_C0,
        BS_DEN,
        BS_DGO,
        BS_DWAIT,
        BS_ZERO
    } t_bstate;

    typedef enum logic [1:0] {
        PH_CROSS,
        PH_DET,
        PH_ENTRY
    } t_phase;

    typedef struct packed {
        logic [4:0] a_sel;
        logic [4:0] b_sel;
    } t_opsel;

    typedef struct packed {
        logic                  go;
        logic signed [OPW-1:0] a;
        logic signed [OPW-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                  done;
        logic signed [PRW-1:0] p;
    } t_mul_rsp;

    typedef struct packed {
        logic                  go;
        logic signed [PRW-1:0] num;
        logic [DENW-1:0]       den;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [VW-1:0] value;
    } t_div_rsp;

    // edge operands of the three cross products, two terms per component
    function automatic t_opsel cross_op(input logic [4:0] step);
        t_opsel r;
        case (step)
            5'd0:  r = '{5'd4, 5'd8};
            5'd1:  r = '{5'd5, 5'd7};
            5'd2:  r = '{5'd5, 5'd6};
            5'd3:  r = '{5'd3, 5'd8};
            5'd4:  r = '{5'd3, 5'd7};
            5'd5:  r = '{5'd4, 5'd6};
            5'd6:  r = '{5'd7, 5'd2};
            5'd7:  r = '{5'd8, 5'd1};
            5'd8:  r = '{5'd8, 5'd0};
            5'd9:  r = '{5'd6, 5'd2};
            5'd10: r = '{5'd6, 5'd1};
            5'd11: r = '{5'd7, 5'd0};
            5'd12: r = '{5'd1, 5'd5};
            5'd13: r = '{5'd2, 5'd4};
            5'd14: r = '{5'd2, 5'd3};
            5'd15: r = '{5'd0, 5'd5};
            5'd16: r = '{5'd0, 5'd4};
            5'd17: r = '{5'd1, 5'd3};
            default: r = '{5'd0, 5'd0};
        endcase
        return r;
    endfunction

endpackage

// ===== src/tle_front.sv =====
module tle_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  tle_pkg::t_coord     i_coord [12],
    output logic                o_q_valid,
    output tle_pkg::t_edges     o_q_edges,
    input  logic                i_q_pop
);

    tle_pkg::t_edges r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    tle_pkg::t_edges n_edges;
    logic            push;

    assign o_busy    = (r_cnt == 2'd2);
    assign push      = i_start && !o_busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_edges = r_q[r_rp];

    // edge vectors relative to vertex 0
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                n_edges[3*a+b] = tle_pkg::EW'(i_coord[3*(a+1)+b])
                               - tle_pkg::EW'(i_coord[b]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_edges;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

// ===== src/tle_mul.sv =====
module tle_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tle_pkg::t_mul_req i_req,
    output tle_pkg::t_mul_rsp o_rsp
);

    localparam int BW = tle_pkg::NDIG * tle_pkg::DGW;

    logic                      r_busy;
    logic [2:0]                r_cnt;
    logic [tle_pkg::OPW-1:0]   r_a;
    logic [BW-1:0]             r_b;
    logic                      r_neg;
    logic [tle_pkg::PRW-1:0]   r_acc;
    logic                      r_done;
    logic [tle_pkg::PRW-1:0]   r_p;
    logic [tle_pkg::OPW-1:0]   mag_a;
    logic [tle_pkg::OPW-1:0]   mag_b;
    logic [tle_pkg::OPW+tle_pkg::DGW-1:0] part;

    assign mag_a = i_req.a[tle_pkg::OPW-1] ? tle_pkg::OPW'(-i_req.a) : i_req.a;
    assign mag_b = i_req.b[tle_pkg::OPW-1] ? tle_pkg::OPW'(-i_req.b) : i_req.b;
    // one 16-bit digit of the multiplier per cycle, msb digit first
    assign part  = r_a * r_b[BW-1 -: tle_pkg::DGW];

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_p;

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_a   <= mag_a;
            r_b   <= BW'(mag_b);
            r_neg <= i_req.a[tle_pkg::OPW-1] ^ i_req.b[tle_pkg::OPW-1];
            r_acc <= '0;
        end else if (r_busy && r_cnt != 3'd0) begin
            r_acc <= (r_acc << tle_pkg::DGW) + tle_pkg::PRW'(part);
            r_b   <= r_b << tle_pkg::DGW;
        end
        if (r_busy && r_cnt == 3'd0) begin
            r_p <= r_neg ? -r_acc : r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'(tle_pkg::NDIG);
            end else if (r_busy) begin
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 3'd1;
                end
            end
        end
    end

endmodule

// ===== src/tle_div.sv =====
module tle_div #(
    parameter int NUM_SH = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tle_pkg::t_div_req i_req,
    output tle_pkg::t_div_rsp o_rsp
);

    localparam int                 CNTW = $clog2(tle_pkg::QW + 1);
    localparam logic [tle_pkg::VW-1:0] VMAX = {1'b0, {(tle_pkg::VW-1){1'b1}}};
    localparam logic [tle_pkg::VW-1:0] VMIN = {1'b1, {(tle_pkg::VW-1){1'b0}}};

    logic                      r_busy;
    logic [CNTW-1:0]           r_cnt;
    logic                      r_neg;
    logic [tle_pkg::DIVW-1:0]  r_rem;
    logic [tle_pkg::DIVW-1:0]  r_dd;
    logic [tle_pkg::QW-1:0]    r_q;
    logic                      r_done;
    logic [tle_pkg::VW-1:0]    r_value;
    logic [tle_pkg::PRW-1:0]   mag;
    logic                      ge;
    logic [tle_pkg::VW-1:0]    n_value;

    assign mag = i_req.num[tle_pkg::PRW-1] ? tle_pkg::PRW'(-i_req.num) : i_req.num;
    assign ge  = (r_rem >= r_dd);

    // a set top quotient bit means the rounded value is far out of range
    always_comb begin
        if (!r_neg) begin
            n_value = (r_q > {{(tle_pkg::QW-tle_pkg::VW){1'b0}}, VMAX})
                    ? VMAX : r_q[tle_pkg::VW-1:0];
        end else begin
            n_value = (r_q > {{(tle_pkg::QW-tle_pkg::VW){1'b0}}, VMIN})
                    ? VMIN : tle_pkg::VW'(-r_q[tle_pkg::VW-1:0]);
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_value;

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_neg <= i_req.num[tle_pkg::PRW-1];
            // round half away: (2*mag + den) / (2*den)
            r_rem <= (tle_pkg::DIVW'(mag) << (NUM_SH + 1)) + tle_pkg::DIVW'(i_req.den);
            r_dd  <= tle_pkg::DIVW'(i_req.den) << tle_pkg::QW;
            r_q   <= '0;
        end else if (r_busy && r_cnt != '0) begin
            if (ge) begin
                r_rem <= r_rem - r_dd;
            end
            r_q  <= {r_q[tle_pkg::QW-2:0], ge};
            r_dd <= r_dd >> 1;
        end
        if (r_busy && r_cnt == '0) begin
            r_value <= n_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(tle_pkg::QW);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNTW'(1);
                end
            end
        end
    end

endmodule

// ===== src/tle_back.sv =====
module tle_back #(
    parameter int DEN_SH = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  tle_pkg::t_edges        i_q_edges,
    output logic                   o_q_pop,
    output tle_pkg::t_mul_req      o_mul_req,
    input  tle_pkg::t_mul_rsp      i_mul_rsp,
    output tle_pkg::t_div_req      o_div_req,
    input  tle_pkg::t_div_rsp      i_div_rsp,
    output logic                   o_valid,
    output logic [1:0]             o_row_vertex,
    output logic [1:0]             o_col_vertex,
    output logic [tle_pkg::VW-1:0] o_entry_value,
    output logic                   o_degenerate,
    output logic                   o_last_entry
);

    tle_pkg::t_bstate              r_state;
    tle_pkg::t_bstate              n_state;
    tle_pkg::t_phase               r_phase;
    logic [4:0]                    r_step;
    logic [3:0]                    r_jk;
    tle_pkg::t_edges               r_e;
    logic signed [tle_pkg::OPW-1:0] r_c [tle_pkg::NC];
    logic signed [tle_pkg::PRW-1:0] r_acc;
    logic [tle_pkg::DENW-1:0]      r_den;
    logic                          r_valid;
    logic [1:0]                    r_row;
    logic [1:0]                    r_col;
    logic [tle_pkg::VW-1:0]        r_value;
    logic                          r_degen;
    logic                          r_last;

    tle_pkg::t_opsel               sel;
    logic [4:0]                    j3;
    logic [4:0]                    k3;
    logic [4:0]                    ca;
    logic [4:0]                    cb;
    logic signed [tle_pkg::OPW-1:0] opa;
    logic signed [tle_pkg::OPW-1:0] opb;
    logic signed [tle_pkg::PRW-1:0] acc_sum;
    logic                          step_last;
    logic [tle_pkg::PRW-1:0]       abs_det;
    logic [tle_pkg::DENW-1:0]      den6;

    assign j3 = {2'b00, r_jk[3:2], 1'b0} + {3'b000, r_jk[3:2]};
    assign k3 = {2'b00, r_jk[1:0], 1'b0} + {3'b000, r_jk[1:0]};

    // operand select: codes below SEL_C pick an edge, the rest a cofactor
    always_comb begin
        case (r_phase)
            tle_pkg::PH_CROSS: sel = tle_pkg::cross_op(r_step);
            tle_pkg::PH_DET:   sel = '{r_step, tle_pkg::SEL_C + 5'd3 + r_step};
            tle_pkg::PH_ENTRY: sel = '{tle_pkg::SEL_C + j3 + r_step,
                                       tle_pkg::SEL_C + k3 + r_step};
            default:           sel = '{5'd0, 5'd0};
        endcase
        ca  = sel.a_sel - tle_pkg::SEL_C;
        cb  = sel.b_sel - tle_pkg::SEL_C;
        opa = (sel.a_sel < tle_pkg::SEL_C) ? tle_pkg::OPW'(r_e[sel.a_sel[3:0]])
                                           : r_c[ca[3:0]];
        opb = (sel.b_sel < tle_pkg::SEL_C) ? tle_pkg::OPW'(r_e[sel.b_sel[3:0]])
                                           : r_c[cb[3:0]];
    end

    assign acc_sum   = (r_step == 5'd0) ? i_mul_rsp.p : r_acc + i_mul_rsp.p;
    assign step_last = (r_phase == tle_pkg::PH_CROSS) ? (r_step == tle_pkg::CROSS_LAST)
                                                      : (r_step == tle_pkg::SUM_LAST);
    assign abs_det   = r_acc[tle_pkg::PRW-1] ? tle_pkg::PRW'(-r_acc) : r_acc;
    assign den6      = tle_pkg::DENW'(abs_det << 2) + tle_pkg::DENW'(abs_det << 1);

    assign o_valid       = r_valid;
    assign o_row_vertex  = r_row;
    assign o_col_vertex  = r_col;
    assign o_entry_value = r_value;
    assign o_degenerate  = r_degen;
    assign o_last_entry  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tle_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_q_pop       = 1'b0;
        o_mul_req.go  = 1'b0;
        o_mul_req.a   = opa;
        o_mul_req.b   = opb;
        o_div_req.go  = 1'b0;
        o_div_req.num = r_acc;
        o_div_req.den = r_den;
        case (r_state)
            tle_pkg::BS_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = tle_pkg::BS_MGO;
                end
            end
            tle_pkg::BS_MGO: begin
                o_mul_req.go = 1'b1;
                n_state      = tle_pkg::BS_MWAIT;
            end
            tle_pkg::BS_MWAIT: begin
                if (i_mul_rsp.done) begin
                    if (!step_last) begin
                        n_state = tle_pkg::BS_MGO;
                    end else begin
                        case (r_phase)
                            tle_pkg::PH_CROSS: n_state = tle_pkg::BS_C0;
                            tle_pkg::PH_DET:   n_state = tle_pkg::BS_DEN;
                            default:           n_state = tle_pkg::BS_DGO;
                        endcase
                    end
                end
            end
            tle_pkg::BS_C0: begin
                n_state = tle_pkg::BS_MGO;
            end
            tle_pkg::BS_DEN: begin
                n_state = (r_acc == '0) ? tle_pkg::BS_ZERO : tle_pkg::BS_MGO;
            end
            tle_pkg::BS_DGO: begin
                o_div_req.go = 1'b1;
                n_state      = tle_pkg::BS_DWAIT;
            end
            tle_pkg::BS_DWAIT: begin
                if (i_div_rsp.done) begin
                    n_state = (r_jk == tle_pkg::JK_LAST) ? tle_pkg::BS_IDLE
                                                         : tle_pkg::BS_MGO;
                end
            end
            tle_pkg::BS_ZERO: begin
                if (r_jk == tle_pkg::JK_LAST) begin
                    n_state = tle_pkg::BS_IDLE;
                end
            end
            default: n_state = tle_pkg::BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            tle_pkg::BS_IDLE: begin
                r_e     <= i_q_edges;
                r_phase <= tle_pkg::PH_CROSS;
                r_step  <= 5'd0;
            end
            tle_pkg::BS_MWAIT: begin
                if (i_mul_rsp.done) begin
                    if (r_phase == tle_pkg::PH_CROSS) begin
                        // even step holds the first term, odd step finishes a component
                        if (!r_step[0]) begin
                            r_acc <= i_mul_rsp.p;
                        end else begin
                            r_c[4'd3 + r_step[4:1]] <= tle_pkg::OPW'(r_acc - i_mul_rsp.p);
                        end
                    end else begin
                        r_acc <= acc_sum;
                    end
                    r_step <= step_last ? 5'd0 : r_step + 5'd1;
                end
            end
            tle_pkg::BS_C0: begin
                for (int b = 0; b < 3; b++) begin
                    r_c[b] <= -(r_c[3+b] + r_c[6+b] + r_c[9+b]);
                end
                r_phase <= tle_pkg::PH_DET;
            end
            tle_pkg::BS_DEN: begin
                r_den   <= den6 << DEN_SH;
                r_jk    <= 4'd0;
                r_phase <= tle_pkg::PH_ENTRY;
            end
            tle_pkg::BS_DWAIT: begin
                if (i_div_rsp.done) begin
                    r_row   <= r_jk[3:2];
                    r_col   <= r_jk[1:0];
                    r_value <= i_div_rsp.value;
                    r_degen <= 1'b0;
                    r_last  <= (r_jk == tle_pkg::JK_LAST);
                    r_jk    <= r_jk + 4'd1;
                end
            end
            tle_pkg::BS_ZERO: begin
                r_row   <= r_jk[3:2];
                r_col   <= r_jk[1:0];
                r_value <= '0;
                r_degen <= 1'b1;
                r_last  <= (r_jk == tle_pkg::JK_LAST);
                r_jk    <= r_jk + 4'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == tle_pkg::BS_ZERO)
                    || (r_state == tle_pkg::BS_DWAIT && i_div_rsp.done);
        end
    end

endmodule

// ===== src/tet_laplacian_element_matrix.sv =====
// Laplacian element matrix of one linear tetrahedron.
// Input: four vertices (i_x0..i_z3, signed fixed point), taken in the cycle where
// start is high and busy is low. A two-beat queue sits between intake and the
// compute engine, so up to two elements can wait while one is being worked on.
// Output: sixteen beats per element, row-major, each shown for one cycle with
// o_valid high; o_last_entry marks the last beat. The receiver cannot stall.
// Degenerate elements (zero determinant) give sixteen zero beats with
// o_degenerate set, on consecutive cycles.
// Every product goes through one shared 72x16 multiplier (69 products per element,
// 21 when degenerate) and every entry through a divider that resolves one quotient
// bit a cycle. Elements are worked on one at a time; the next one leaves the queue
// only when the engine is idle again.
// Reset clears the queue and the engine.
module tet_laplacian_element_matrix #(
    parameter int COORD_FRAC_BITS = 16,
    parameter int VALUE_FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [31:0]      i_x0,
    input  logic signed [31:0]      i_y0,
    input  logic signed [31:0]      i_z0,
    input  logic signed [31:0]      i_x1,
    input  logic signed [31:0]      i_y1,
    input  logic signed [31:0]      i_z1,
    input  logic signed [31:0]      i_x2,
    input  logic signed [31:0]      i_y2,
    input  logic signed [31:0]      i_z2,
    input  logic signed [31:0]      i_x3,
    input  logic signed [31:0]      i_y3,
    input  logic signed [31:0]      i_z3,
    output logic                    o_valid,
    output logic [1:0]              o_row_vertex,
    output logic [1:0]              o_col_vertex,
    output logic signed [47:0]      o_entry_value,
    output logic                    o_degenerate,
    output logic                    o_last_entry
);

    localparam int DEN_SH = (COORD_FRAC_BITS > VALUE_FRAC_BITS)
                          ? COORD_FRAC_BITS - VALUE_FRAC_BITS : 0;
    localparam int NUM_SH = (VALUE_FRAC_BITS > COORD_FRAC_BITS)
                          ? VALUE_FRAC_BITS - COORD_FRAC_BITS : 0;

    tle_pkg::t_coord   coord [12];
    logic              q_valid;
    tle_pkg::t_edges   q_edges;
    logic              q_pop;
    tle_pkg::t_mul_req mul_req;
    tle_pkg::t_mul_rsp mul_rsp;
    tle_pkg::t_div_req div_req;
    tle_pkg::t_div_rsp div_rsp;
    logic [47:0]       entry_value;

    assign coord[0]  = i_x0;
    assign coord[1]  = i_y0;
    assign coord[2]  = i_z0;
    assign coord[3]  = i_x1;
    assign coord[4]  = i_y1;
    assign coord[5]  = i_z1;
    assign coord[6]  = i_x2;
    assign coord[7]  = i_y2;
    assign coord[8]  = i_z2;
    assign coord[9]  = i_x3;
    assign coord[10] = i_y3;
    assign coord[11] = i_z3;

    assign o_entry_value = entry_value;

    tle_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (busy),
        .i_coord   (coord),
        .o_q_valid (q_valid),
        .o_q_edges (q_edges),
        .i_q_pop   (q_pop)
    );

    tle_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    tle_div #(
        .NUM_SH (NUM_SH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tle_back #(
        .DEN_SH (DEN_SH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_edges     (q_edges),
        .o_q_pop       (q_pop),
        .o_mul_req     (mul_req),
        .i_mul_rsp     (mul_rsp),
        .o_div_req     (div_req),
        .i_div_rsp     (div_rsp),
        .o_valid       (o_valid),
        .o_row_vertex  (o_row_vertex),
        .o_col_vertex  (o_col_vertex),
        .o_entry_value (entry_value),
        .o_degenerate  (o_degenerate),
        .o_last_entry  (o_last_entry)
    );

`ifndef SYNTH
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_entry |-> o_row_vertex == 2'd3 && o_col_vertex == 2'd3)
        else $error("last beat not at corner entry");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_entry_value == '0)
        else $error("degenerate beat carries a value");

    a_div_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate |=> !o_valid)
        else $error("divided beats back to back");
`endif

endmodule
